// File: rtl/fsba_pkg.sv
// Package: constants, codes and types for the fit select block allocator.
`default_nettype none
package fsba_pkg;
   localparam int MaxBlocks = 64;
   localparam int SlotW = $clog2(MaxBlocks);
   localparam int PtrW = SlotW + 1;
   localparam int AddrW = 21;
   localparam int HeapBytes = 1048576;
   localparam logic [PtrW-1:0] NIL = PtrW'(MaxBlocks);

   localparam logic [1:0] FIT_FIRST = 2'd0;
   localparam logic [1:0] FIT_BEST = 2'd1;
   localparam logic [1:0] FIT_NEXT = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_ZERO = 2'd1;
   localparam logic [1:0] ST_NOMEM = 2'd2;
   localparam logic [1:0] ST_BADADDR = 2'd3;

   localparam logic [1:0] REG_FIT_MODE = 2'd0;
   localparam logic [1:0] REG_HEADER = 2'd1;
   localparam logic [1:0] REG_ALIGN = 2'd2;
   localparam logic [1:0] REG_LIMIT = 2'd3;

   typedef struct packed {
      logic [AddrW-1:0] start;
      logic [AddrW-1:0] size;
      logic             free;
      logic [PtrW-1:0]  next;
   } entry_type;
endpackage
`default_nettype wire

// File: rtl/fsba_if.sv
// Interfaces: request, response and register write channels.
`default_nettype none
interface fsba_req_if;
   logic                   valid;
   logic                   ready;
   logic                   op;
   logic [20:0]            req_size;
   logic [20:0]            data_addr;
   modport source (output valid, op, req_size, data_addr, input ready);
   modport sink (input valid, op, req_size, data_addr, output ready);
endinterface

interface fsba_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [20:0] result_addr;
   modport source (output valid, status, result_addr, input ready);
   modport sink (input valid, status, result_addr, output ready);
endinterface

interface fsba_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [20:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/fsba_table.sv
// Block table memory: one write port, one registered read port.
`default_nettype none
module fsba_table
   import fsba_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [SlotW-1:0] wr_addr,
   input  wire entry_type        wr_data,
   input  wire logic [SlotW-1:0] rd_addr,
   output entry_type             rd_data
);
   entry_type mem [MaxBlocks];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// File: rtl/fit_select_block_allocator_top.sv
// Top level: heap allocator over an address-ordered block table.
//
// Channels: req (op, req_size, data_addr) and rsp (status, result_addr),
// both valid/ready; a transfer happens when valid and ready are high at a
// rising clock edge. csr writes fit_mode, header_bytes, align_shift and
// heap_limit by index; the user must write them while the block is idle;
// the block itself leaves this unchecked. One item is worked at a time.
// The block table of 64 slots sits in one synchronous memory; the chain
// is walked entry by entry, each step waiting on the memory's registered
// read (S_RD, then S_EXAM). First or next fit stop at the hit, best fit
// walks the whole chain unless it meets an exact fit, a free stops at its
// block. A split writes the remainder in S_BRD, an append links the old
// tail in S_TAIL, a free reads the next block in S_NRD and S_NEX to merge
// it if free. A zero size answers in the cycle after the request transfer,
// and the next request waits for the cycle after the response transfer.
// Reset empties the table at once (slot map all unused, head, tail,
// cursor null, break zero) and loads the register reset values.
// The response waits in an output register while the receiver stalls;
// the next request is taken once that register is free.
`default_nettype none
module fit_select_block_allocator_top
   import fsba_pkg::*;
(
   input wire logic  clock,
   input wire logic  reset,
   fsba_req_if.sink  req,
   fsba_rsp_if.source rsp,
   fsba_csr_if.sink  csr
);
   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_RD = 4'd1;
   localparam logic [3:0] S_EXAM = 4'd2;
   localparam logic [3:0] S_PICK = 4'd3;
   localparam logic [3:0] S_BRD = 4'd4;
   localparam logic [3:0] S_BEX = 4'd5;
   localparam logic [3:0] S_TAIL = 4'd6;
   localparam logic [3:0] S_NRD = 4'd7;
   localparam logic [3:0] S_NEX = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       fit_mode_ff;
   logic [7:0]       header_ff;
   logic [2:0]       align_ff;
   logic [AddrW-1:0] limit_ff;
   logic [MaxBlocks-1:0] unused_ff, unused_in;
   logic [PtrW-1:0]  head_ff, head_in, tail_ff, tail_in, cursor_ff, cursor_in;
   logic [AddrW-1:0] break_ff, break_in;

   logic             op_ff, op_in;
   logic [22:0]      size_ff, size_in;
   logic [AddrW-1:0] addr_ff, addr_in;
   logic [PtrW-1:0]  cur_ff, cur_in, begin_ff, begin_in, best_ff, best_in;
   logic [AddrW-1:0] best_size_ff, best_size_in;
   logic [PtrW-1:0]  hit_ff, hit_in;
   logic [SlotW:0]   count_ff, count_in;
   entry_type        blk_ff, blk_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [1:0]       status_ff, status_in;
   logic [AddrW-1:0] res_ff, res_in;

   logic             wr_en;
   logic [SlotW-1:0] wr_addr, rd_addr;
   entry_type        wr_data, rd_data;

   fsba_table u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   logic [PtrW-1:0] free_slot;
   always_comb begin
      free_slot = NIL;
      for (int i = MaxBlocks - 1; i >= 0; i--) begin
         if (unused_ff[i]) begin
            free_slot = PtrW'(i);
         end
      end
   end

   logic [22:0] align_mask, rounded;
   logic [AddrW-1:0] lim;
   logic        fit_hit;
   logic [23:0] need_split, end_brk;
   logic [PtrW-1:0] nxt_wrap;
   always_comb begin
      align_mask = (23'd1 << align_ff) - 23'd1;
      rounded = (23'(req.req_size) + align_mask) & ~align_mask;
      lim = (limit_ff < AddrW'(HeapBytes)) ? limit_ff : AddrW'(HeapBytes);
      fit_hit = rd_data.free && (24'(rd_data.size) >= 24'(size_ff));
      need_split = 24'(size_ff) + 24'(header_ff);
      end_brk = 24'(break_ff) + 24'(header_ff) + 24'(size_ff);
      nxt_wrap = (rd_data.next != NIL) ? rd_data.next : head_ff;
   end

   assign req.ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr.ready = 1'b1;
   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = status_ff;
   assign rsp.result_addr = res_ff;

   always_comb begin
      state_in = state_ff;
      unused_in = unused_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      cursor_in = cursor_ff;
      break_in = break_ff;
      op_in = op_ff;
      size_in = size_ff;
      addr_in = addr_ff;
      cur_in = cur_ff;
      begin_in = begin_ff;
      best_in = best_ff;
      best_size_in = best_size_ff;
      hit_in = hit_ff;
      count_in = count_ff;
      blk_in = blk_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      status_in = status_ff;
      res_in = res_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff[SlotW-1:0];
      wr_data = blk_ff;
      rd_addr = cur_ff[SlotW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (req.valid && req.ready) begin
               op_in = req.op;
               size_in = rounded;
               addr_in = req.data_addr;
               count_in = '0;
               best_in = NIL;
               best_size_in = '0;
               hit_in = NIL;
               if (!req.op && req.req_size == '0) begin
                  status_in = ST_ZERO;
                  res_in = '0;
                  rsp_valid_in = 1'b1;
               end else if (!req.op && fit_mode_ff == FIT_NEXT) begin
                  cur_in = (cursor_ff != NIL) ? cursor_ff : head_ff;
                  begin_in = cur_in;
                  state_in = (head_ff == NIL) ? S_PICK : S_RD;
               end else begin
                  cur_in = head_ff;
                  state_in = (head_ff == NIL) ? S_PICK : S_RD;
               end
            end
         end
         S_RD: begin
            state_in = S_EXAM;
         end
         S_EXAM: begin
            count_in = count_ff + 1'b1;
            state_in = S_RD;
            cur_in = rd_data.next;
            if (op_ff) begin
               if (24'(rd_data.start) + 24'(header_ff) == 24'(addr_ff)) begin
                  hit_in = cur_ff;
                  blk_in = rd_data;
                  blk_in.free = 1'b1;
                  state_in = S_PICK;
               end else if (rd_data.next == NIL) begin
                  state_in = S_PICK;
               end
            end else if (fit_mode_ff == FIT_BEST) begin
               if (fit_hit && 24'(rd_data.size) == 24'(size_ff)) begin
                  hit_in = cur_ff;
                  blk_in = rd_data;
                  state_in = S_PICK;
               end else begin
                  if (fit_hit && (best_ff == NIL || rd_data.size < best_size_ff)) begin
                     best_in = cur_ff;
                     best_size_in = rd_data.size;
                     hit_in = cur_ff;
                     blk_in = rd_data;
                  end
                  if (rd_data.next == NIL) begin
                     state_in = S_PICK;
                  end
               end
            end else if (fit_mode_ff == FIT_NEXT) begin
               cur_in = nxt_wrap;
               if (fit_hit) begin
                  hit_in = cur_ff;
                  blk_in = rd_data;
                  cursor_in = rd_data.next;
                  state_in = S_PICK;
               end else if (nxt_wrap == begin_ff) begin
                  state_in = S_PICK;
               end
            end else begin
               if (fit_hit) begin
                  hit_in = cur_ff;
                  blk_in = rd_data;
                  state_in = S_PICK;
               end else if (rd_data.next == NIL) begin
                  state_in = S_PICK;
               end
            end
         end
         S_PICK: begin
            state_in = S_DONE;
            rsp_valid_in = 1'b0;
            status_in = ST_OK;
            res_in = '0;
            if (op_ff) begin
               if (hit_ff == NIL) begin
                  status_in = ST_BADADDR;
               end else if (blk_ff.next != NIL) begin
                  cur_in = blk_ff.next;
                  state_in = S_NRD;
               end else begin
                  wr_en = 1'b1;
                  wr_addr = hit_ff[SlotW-1:0];
               end
            end else if (hit_ff != NIL) begin
               res_in = blk_ff.start + AddrW'(header_ff);
               wr_en = 1'b1;
               wr_addr = hit_ff[SlotW-1:0];
               wr_data = blk_ff;
               wr_data.free = 1'b0;
               if (24'(blk_ff.size) >= need_split && free_slot != NIL) begin
                  wr_data.size = size_ff[AddrW-1:0];
                  wr_data.next = free_slot;
                  unused_in[free_slot[SlotW-1:0]] = 1'b0;
                  if (tail_ff == hit_ff) begin
                     tail_in = free_slot;
                  end
                  blk_in.start = blk_ff.start + AddrW'(header_ff) + size_ff[AddrW-1:0];
                  blk_in.size = AddrW'(24'(blk_ff.size) - need_split);
                  blk_in.free = 1'b1;
                  cur_in = free_slot;
                  state_in = S_BRD;
               end
            end else if (free_slot == NIL || end_brk > 24'(lim)) begin
               status_in = ST_NOMEM;
            end else begin
               res_in = break_ff + AddrW'(header_ff);
               wr_en = 1'b1;
               wr_addr = free_slot[SlotW-1:0];
               wr_data.start = break_ff;
               wr_data.size = size_ff[AddrW-1:0];
               wr_data.free = 1'b0;
               wr_data.next = NIL;
               unused_in[free_slot[SlotW-1:0]] = 1'b0;
               break_in = end_brk[AddrW-1:0];
               tail_in = free_slot;
               cur_in = free_slot;
               if (tail_ff == NIL) begin
                  head_in = free_slot;
               end else begin
                  hit_in = tail_ff;
                  rd_addr = tail_ff[SlotW-1:0];
                  state_in = S_TAIL;
               end
            end
         end
         S_BRD: begin
            wr_en = 1'b1;
            wr_addr = cur_ff[SlotW-1:0];
            wr_data = blk_ff;
            state_in = S_DONE;
         end
         S_TAIL: begin
            wr_en = 1'b1;
            wr_addr = hit_ff[SlotW-1:0];
            wr_data = rd_data;
            wr_data.next = cur_ff;
            state_in = S_DONE;
         end
         S_NRD: begin
            state_in = S_NEX;
         end
         S_NEX: begin
            wr_en = 1'b1;
            wr_addr = hit_ff[SlotW-1:0];
            wr_data = blk_ff;
            if (rd_data.free) begin
               wr_data.size = AddrW'(24'(blk_ff.size) + 24'(rd_data.size) + 24'(header_ff));
               wr_data.next = rd_data.next;
               unused_in[cur_ff[SlotW-1:0]] = 1'b1;
               if (tail_ff == cur_ff) begin
                  tail_in = hit_ff;
               end
               if (cursor_ff == cur_ff) begin
                  cursor_in = hit_ff;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (state_ff == S_EXAM && count_ff == (SlotW+1)'(MaxBlocks) && state_in == S_RD) begin
         state_in = S_PICK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fit_mode_ff <= FIT_FIRST;
         header_ff <= 8'd40;
         align_ff <= 3'd3;
         limit_ff <= AddrW'(HeapBytes);
         unused_ff <= '1;
         head_ff <= NIL;
         tail_ff <= NIL;
         cursor_ff <= NIL;
         break_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         unused_ff <= unused_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         cursor_ff <= cursor_in;
         break_ff <= break_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr.valid && csr.ready) begin
            unique case (csr.index)
               REG_FIT_MODE: fit_mode_ff <= csr.data[1:0];
               REG_HEADER: header_ff <= csr.data[7:0];
               REG_ALIGN: align_ff <= csr.data[2:0];
               REG_LIMIT: limit_ff <= csr.data;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      size_ff <= size_in;
      addr_ff <= addr_in;
      cur_ff <= cur_in;
      begin_ff <= begin_in;
      best_ff <= best_in;
      best_size_ff <= best_size_in;
      hit_ff <= hit_in;
      count_ff <= count_in;
      blk_ff <= blk_in;
      status_ff <= status_in;
      res_ff <= res_in;
   end
endmodule
`default_nettype wire

// File: rtl/fsba_checker.sv
// Port checker for the allocator top level, with its bind.
`default_nettype none
module fsba_checker
   import fsba_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic [20:0] rsp_result_addr
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_addr))
      else $error("stalled response changed");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_result_addr == '0)
      else $error("failed item carries an address");
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while busy");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");
endmodule

bind fit_select_block_allocator_top fsba_checker u_fsba_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_status     (rsp.status),
   .rsp_result_addr(rsp.result_addr)
);
`default_nettype wire

// File: tb/sv/fsba_tb_pkg.sv
// Testbench package: allocator predictor state and the operations that update it.
`timescale 1ns / 1ps
package fsba_tb_pkg;
   import fsba_pkg::*;

   typedef struct {
      logic [AddrW-1:0] start;
      logic [AddrW-1:0] size;
      bit               free;
      int               next;
   } blk_type;

   typedef struct {
      logic [1:0]       status;
      logic [AddrW-1:0] addr;
   } outcome_type;

   blk_type  blk[MaxBlocks];
   bit       slot_used[MaxBlocks];
   int       chain_head, chain_tail, rover;
   logic [AddrW-1:0] brk;
   logic [1:0]       mode_reg;
   logic [7:0]       hdr_reg;
   logic [2:0]       shift_reg;
   logic [AddrW-1:0] limit_reg;

   function automatic void clear_heap();
      foreach (slot_used[i]) slot_used[i] = 0;
      chain_head = MaxBlocks;
      chain_tail = MaxBlocks;
      rover = MaxBlocks;
      brk = '0;
      mode_reg = FIT_FIRST;
      hdr_reg = 8'd40;
      shift_reg = 3'd3;
      limit_reg = AddrW'(HeapBytes);
   endfunction

   function automatic void write_reg(logic [1:0] idx, logic [AddrW-1:0] val);
      case (idx)
         REG_FIT_MODE: mode_reg = val[1:0];
         REG_HEADER: hdr_reg = val[7:0];
         REG_ALIGN: shift_reg = val[2:0];
         default: limit_reg = val;
      endcase
   endfunction

   function automatic int free_slot();
      for (int i = 0; i < MaxBlocks; i++)
         if (!slot_used[i]) return i;
      return MaxBlocks;
   endfunction

   function automatic bit holds(int i, longint sz);
      return blk[i].free && longint'(blk[i].size) >= sz;
   endfunction

   function automatic int find_block(longint sz);
      int c, best, first, n;
      best = MaxBlocks;
      n = 0;
      if (mode_reg == FIT_NEXT) begin
         if (chain_head >= MaxBlocks) return MaxBlocks;
         first = (rover < MaxBlocks) ? rover : chain_head;
         c = first;
         do begin
            if (holds(c, sz)) begin
               rover = blk[c].next;
               return c;
            end
            c = (blk[c].next < MaxBlocks) ? blk[c].next : chain_head;
            n++;
         end while (c != first && n <= MaxBlocks);
         return MaxBlocks;
      end
      c = chain_head;
      while (c < MaxBlocks && n <= MaxBlocks) begin
         if (holds(c, sz)) begin
            if (mode_reg != FIT_BEST || longint'(blk[c].size) == sz) return c;
            if (best >= MaxBlocks || blk[c].size < blk[best].size) best = c;
         end
         c = blk[c].next;
         n++;
      end
      return best;
   endfunction

   function automatic outcome_type allocate(logic [AddrW-1:0] req_sz);
      outcome_type o;
      longint al, sz, hd, lim;
      int b, s;
      o.status = ST_OK;
      o.addr = '0;
      if (req_sz == 0) begin
         o.status = ST_ZERO;
         return o;
      end
      al = longint'(1) << shift_reg;
      sz = (longint'(req_sz) + al - 1) & ~(al - 1);
      hd = hdr_reg;
      b = find_block(sz);
      if (b < MaxBlocks) begin
         if (longint'(blk[b].size) >= sz + hd) begin
            s = free_slot();
            if (s < MaxBlocks) begin
               slot_used[s] = 1;
               blk[s].start = AddrW'(longint'(blk[b].start) + hd + sz);
               blk[s].size = AddrW'(longint'(blk[b].size) - sz - hd);
               blk[s].free = 1;
               blk[s].next = blk[b].next;
               blk[b].next = s;
               blk[b].size = AddrW'(sz);
               if (chain_tail == b) chain_tail = s;
            end
         end
         blk[b].free = 0;
         o.addr = AddrW'(longint'(blk[b].start) + hd);
         return o;
      end
      lim = (limit_reg < HeapBytes) ? limit_reg : HeapBytes;
      s = free_slot();
      if (s >= MaxBlocks || longint'(brk) + hd + sz > lim) begin
         o.status = ST_NOMEM;
         return o;
      end
      slot_used[s] = 1;
      blk[s].start = brk;
      blk[s].size = AddrW'(sz);
      blk[s].free = 0;
      blk[s].next = MaxBlocks;
      if (chain_tail < MaxBlocks) blk[chain_tail].next = s;
      else chain_head = s;
      chain_tail = s;
      brk = AddrW'(longint'(brk) + hd + sz);
      o.addr = AddrW'(longint'(blk[s].start) + hd);
      return o;
   endfunction

   function automatic outcome_type release_block(logic [AddrW-1:0] addr);
      outcome_type o;
      int c, n, nx;
      o.status = ST_OK;
      o.addr = '0;
      c = chain_head;
      n = 0;
      while (c < MaxBlocks && n <= MaxBlocks) begin
         if (longint'(blk[c].start) + hdr_reg == longint'(addr)) break;
         c = blk[c].next;
         n++;
      end
      if (c >= MaxBlocks || n > MaxBlocks) begin
         o.status = ST_BADADDR;
         return o;
      end
      blk[c].free = 1;
      nx = blk[c].next;
      if (nx < MaxBlocks && blk[nx].free) begin
         blk[c].size = AddrW'(longint'(blk[c].size) + blk[nx].size + hdr_reg);
         blk[c].next = blk[nx].next;
         slot_used[nx] = 0;
         if (chain_tail == nx) chain_tail = c;
         if (rover == nx) rover = c;
      end
      return o;
   endfunction

   function automatic logic [AddrW-1:0] some_live_addr();
      int c, n, pick;
      logic [AddrW-1:0] a;
      c = chain_head;
      n = 0;
      while (c < MaxBlocks) begin
         n++;
         c = blk[c].next;
      end
      if (n == 0) return AddrW'($urandom_range(0, 2000));
      pick = $urandom_range(0, n - 1);
      c = chain_head;
      repeat (pick) c = blk[c].next;
      a = AddrW'(longint'(blk[c].start) + hdr_reg);
      return a;
   endfunction
endpackage

// File: tb/sv/fit_select_block_allocator_top_test.sv
// Testbench top: drives allocate and free transfers, predicts and checks each response.
`timescale 1ns / 1ps
module fit_select_block_allocator_top_test;
   import fsba_pkg::*;
   import fsba_tb_pkg::*;

   typedef struct {
      bit               op;
      logic [AddrW-1:0] size;
      logic [AddrW-1:0] addr;
      bit               live;
   } job_type;

   logic clock;
   logic reset;
   fsba_req_if req ();
   fsba_rsp_if rsp ();
   fsba_csr_if csr ();

   fit_select_block_allocator_top dut (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp), .csr(csr)
   );

   job_type     pending_jobs[$];
   outcome_type awaited[$];
   int          errors = 0;
   int          quiet = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          stim_done = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // predict at acceptance so live addresses follow the model state
   always @(posedge clock) begin
      job_type j;
      if (reset) begin
         req.valid <= 0;
         req.op <= 0;
         req.req_size <= '0;
         req.data_addr <= '0;
         gap_left <= 0;
      end else begin
         if (req.valid && req.ready) begin
            j = pending_jobs.pop_front();
            awaited.push_back(j.op ? release_block(req.data_addr) : allocate(req.req_size));
         end
         if (req.valid && !req.ready) begin
         end else if (gap_left > 0) begin
            req.valid <= 0;
            gap_left <= gap_left - 1;
         end else if (pending_jobs.size() > (req.valid && req.ready ? 0 : 0) &&
                      pending_jobs.size() > 0 && !(req.valid && req.ready)) begin
            j = pending_jobs[0];
            req.valid <= 1;
            req.op <= j.op;
            req.req_size <= j.size;
            req.data_addr <= (j.op && j.live) ? some_live_addr() : j.addr;
            gap_left <= gap_len();
         end else begin
            req.valid <= 0;
         end
      end
   end

   always @(posedge clock) begin
      outcome_type e;
      if (reset) begin
         rsp.ready <= 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (awaited.size() == 0) begin
               $error("unexpected response status=%0d addr=%0d", rsp.status, rsp.result_addr);
               errors++;
            end else begin
               e = awaited.pop_front();
               if (rsp.status !== e.status) begin
                  $error("status expected %0d actual %0d", e.status, rsp.status);
                  errors++;
               end
               if (rsp.result_addr !== e.addr) begin
                  $error("result_addr expected %0d actual %0d", e.addr, rsp.result_addr);
                  errors++;
               end
            end
         end
         if (stall_left > 0) begin
            rsp.ready <= 0;
            stall_left <= stall_left - 1;
         end else begin
            rsp.ready <= 1;
            stall_left <= (rsp.valid && rsp.ready) ? gap_len() : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
          (csr.valid && csr.ready)) begin
         quiet <= 0;
      end else begin
         quiet <= quiet + 1;
         if (quiet > 20000) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      while (pending_jobs.size() > 0 || awaited.size() > 0 || req.valid)
         @(posedge clock);
      repeat (160) @(posedge clock);
   endtask

   task automatic set_reg(logic [1:0] idx, logic [AddrW-1:0] val);
      csr.valid <= 1;
      csr.index <= idx;
      csr.data <= val;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      write_reg(idx, val);
      csr.valid <= 0;
      @(posedge clock);
   endtask

   task automatic add_job(bit op, logic [AddrW-1:0] sz, logic [AddrW-1:0] ad, bit live);
      job_type j;
      j.op = op;
      j.size = sz;
      j.addr = ad;
      j.live = live;
      pending_jobs.push_back(j);
   endtask

   task automatic random_phase(int n, int max_sz);
      int r;
      repeat (n) begin
         r = $urandom_range(0, 99);
         if (r < 50) add_job(0, AddrW'($urandom_range(1, max_sz)), '0, 0);
         else if (r < 88) add_job(1, '0, '0, 1);
         else if (r < 92) add_job(0, '0, AddrW'($urandom), 0);
         else if (r < 96) add_job(1, AddrW'($urandom), AddrW'($urandom_range(0, 2000)), 0);
         else add_job(0, AddrW'($urandom_range(0, 1 << 21 - 1)), '0, 0);
      end
   endtask

   initial begin
      csr.valid = 0; csr.index = REG_FIT_MODE; csr.data = 0;
      clear_heap();
      reset = 1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      add_job(0, '0, '1, 0);
      add_job(0, 21'd1, '0, 0);
      add_job(0, 21'd100, '0, 0);
      add_job(0, 21'd7, '0, 0);
      add_job(1, '1, 21'd48, 0);
      add_job(1, '0, 21'd48, 0);
      add_job(1, '0, 21'd3, 0);
      add_job(0, 21'd8, '0, 0);
      add_job(0, 21'h100000, '0, 0);
      add_job(0, '1, '0, 0);
      add_job(1, '0, '1, 0);
      add_job(1, '0, 21'd40, 0);
      add_job(1, '0, 21'd40, 0);
      add_job(0, 21'd24, '0, 0);
      wait_idle();

      set_reg(REG_FIT_MODE, AddrW'(FIT_BEST));
      set_reg(REG_HEADER, 21'd0);
      set_reg(REG_ALIGN, 21'd0);
      set_reg(REG_LIMIT, 21'd3000);
      random_phase(250, 300);
      wait_idle();

      set_reg(REG_FIT_MODE, AddrW'(FIT_NEXT));
      set_reg(REG_HEADER, 21'd255);
      set_reg(REG_ALIGN, 21'd6);
      set_reg(REG_LIMIT, '1);
      random_phase(250, 700);
      wait_idle();

      set_reg(REG_FIT_MODE, 21'd3);
      set_reg(REG_HEADER, 21'd16);
      set_reg(REG_ALIGN, 21'd4);
      set_reg(REG_LIMIT, 21'd0);
      random_phase(40, 100);
      wait_idle();
      set_reg(REG_LIMIT, 21'd20000);
      random_phase(300, 200);
      wait_idle();

      set_reg(REG_FIT_MODE, AddrW'(FIT_FIRST));
      set_reg(REG_ALIGN, 21'd2);
      set_reg(REG_LIMIT, 21'h100000);
      random_phase(250, 5000);
      wait_idle();

      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
